// ----- rtl/hsc_pkg.sv -----
// Shared types and constants for the half/single converter.
package hsc_pkg;

   typedef enum logic {
      DIR_H2S = 1'b0,
      DIR_S2H = 1'b1
   } dir_type;

   localparam logic [30:0] SGL_INF_BITS     = 31'h7F800000;
   localparam logic [30:0] SGL_HALF_MAX     = 31'h477FE000;
   localparam logic [30:0] SGL_HALF_MINNORM = 31'h38800000;
   localparam logic [14:0] HALF_INF         = 15'h7C00;
   localparam logic [17:0] EXP_REBIAS_HALF  = 18'h1C000;

   typedef enum logic [2:0] {
      CLS_NAN   = 3'd0,
      CLS_INF   = 3'd1,
      CLS_NORM  = 3'd2,
      CLS_SUB   = 3'd3,
      CLS_ZERO  = 3'd4
   } cls_type;

endpackage

// ----- rtl/half_single_converter.sv -----
// Top level of the binary16/binary32 converter pipeline.
//
// The block converts one bit pattern per item between IEEE binary16 and
// binary32. The req_ channel carries req_type (0 for half to single, 1 for
// single to half) and the operand; the rsp_ channel returns converted.
// Half to single is exact. Single to half truncates the mantissa, saturates
// large finite values to infinity, and keeps NaN as NaN.
// An accepted item is registered in the three stages in turn, and one item
// can be accepted in every cycle while req_ready is high. Each stage holds
// a valid bit; the first stage classifies the operand, the second does the
// leading-one search or subnormal shift, and the third assembles the result.
// When the receiver stalls, a stage advances only into a free stage, so
// items are held in place and none is lost or repeated; req_ready falls
// only when all three stages are full.
// Reset empties the pipeline; no item is pending afterward.
module half_single_converter
   import hsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_converted
);

   // Stage 1: classification.
   logic        v1_ff, v1_in;
   dir_type     d1_ff;
   cls_type     c1_ff, c1_in;
   logic [31:0] op1_ff;

   // Stage 2: shift work.
   logic        v2_ff;
   dir_type     d2_ff;
   cls_type     c2_ff;
   logic [31:0] op2_ff;
   logic [3:0]  p2_ff, p2_in;
   logic [9:0]  sub2_ff, sub2_in;

   // Stage 3: output register.
   logic        v3_ff;
   logic [31:0] res3_ff, res3_in;

   logic adv3, adv2, adv1;

   assign adv3 = !v3_ff || rsp_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ready = adv1;

   assign rsp_valid     = v3_ff;
   assign rsp_converted = res3_ff;

   always_comb begin
      logic [30:0] a;
      logic [4:0]  he;
      logic [9:0]  hm;
      a  = req_operand[30:0];
      he = req_operand[14:10];
      hm = req_operand[9:0];
      if (dir_type'(req_type) == DIR_H2S) begin
         if (he == 5'd31)      c1_in = CLS_NAN;
         else if (he != 5'd0)  c1_in = CLS_NORM;
         else if (hm != 10'd0) c1_in = CLS_SUB;
         else                  c1_in = CLS_ZERO;
      end else begin
         if (a > SGL_INF_BITS)            c1_in = CLS_NAN;
         else if (a > SGL_HALF_MAX)       c1_in = CLS_INF;
         else if (a >= SGL_HALF_MINNORM)  c1_in = CLS_NORM;
         else if (a[30:23] != 8'd0)       c1_in = CLS_SUB;
         else                             c1_in = CLS_ZERO;
      end
      v1_in = req_valid;
   end

   always_comb begin
      logic [7:0]  sh;
      logic [23:0] mant;
      logic [23:0] shifted;
      p2_in = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (op1_ff[i]) p2_in = 4'(i);
      end
      sh      = 8'd126 - op1_ff[30:23];
      mant    = {1'b1, op1_ff[22:0]};
      shifted = (sh >= 8'd24) ? 24'd0 : (mant >> sh[4:0]);
      sub2_in = shifted[9:0];
   end

   always_comb begin
      logic [31:0] r;
      logic [9:0]  nm;
      logic [17:0] hn;
      logic [9:0]  mnorm;
      r     = 32'd0;
      nm    = op2_ff[22:13];
      hn    = op2_ff[30:13] - EXP_REBIAS_HALF;
      mnorm = 10'(op2_ff[9:0] << (4'd10 - p2_ff));
      if (d2_ff == DIR_H2S) begin
         unique case (c2_ff)
            CLS_NAN:  r = {1'b0, SGL_INF_BITS} | {9'd0, op2_ff[9:0], 13'd0};
            CLS_NORM: r = {1'b0, 8'(op2_ff[14:10]) + 8'd112, op2_ff[9:0], 13'd0};
            CLS_SUB:  r = {1'b0, 8'(p2_ff) + 8'd103, mnorm, 13'd0};
            default:  r = 32'd0;
         endcase
         r[31] = op2_ff[15];
      end else begin
         unique case (c2_ff)
            CLS_NAN:  r = {17'd0, HALF_INF | {5'd0, (nm == 10'd0) ? 10'd1 : nm}};
            CLS_INF:  r = {17'd0, HALF_INF};
            CLS_NORM: r = {17'd0, hn[14:0]};
            CLS_SUB:  r = {22'd0, sub2_ff};
            default:  r = 32'd0;
         endcase
         r[15] = op2_ff[31];
      end
      res3_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= v1_in;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
      if (adv1) begin
         d1_ff  <= dir_type'(req_type);
         c1_ff  <= c1_in;
         op1_ff <= req_operand;
      end
      if (adv2) begin
         d2_ff   <= d1_ff;
         c2_ff   <= c1_ff;
         op2_ff  <= op1_ff;
         p2_ff   <= p2_in;
         sub2_ff <= sub2_in;
      end
      if (adv3) res3_ff <= res3_in;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_converted))
      else $error("result changed while stalled");
   a_half_upper: assert property (@(posedge clock) disable iff (reset)
      v2_ff && adv3 && d2_ff == DIR_S2H |=> rsp_converted[31:16] == 16'd0)
      else $error("half result has upper bits set");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !v3_ff |=> v3_ff)
      else $error("stage two did not advance into a free output");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> v1_ff && v2_ff && v3_ff)
      else $error("input stalled with a free stage");

endmodule
